/* rtl/core/sha1_message_digest_top_macros.svh */
// Assertion macros shared by the SHA-1 digest block.
`ifndef SHA1_MESSAGE_DIGEST_TOP_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_TOP_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define SHA1MD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sha1md_pkg.sv */
// Types, constants and helper functions of the SHA-1 digest block.
package sha1md_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned LastRound  = 79;

  localparam logic [31:0] InitH [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  // Word index that holds the upper half of the length field.
  localparam logic [3:0] LenHiIdx = 4'd14;
  localparam logic [3:0] LenLoIdx = 4'd15;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ENDW  = 6'b000010,
    ST_PAD   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

/* rtl/core/sha1md_if.sv */
// Valid/ready channel interfaces for message bytes and digests.
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_upper;
  logic [63:0] digest_middle;
  logic [31:0] digest_lower;

  modport source (output valid, digest_upper, digest_middle, digest_lower, input ready);
  modport sink   (input valid, digest_upper, digest_middle, digest_lower, output ready);
endinterface

/* rtl/core/sha1_message_digest_top.sv */
// SHA-1 digest engine: at most one message byte per input beat, one digest beat per message.
// Usage: msg_i carries one beat per byte (byte_present) and marks the last beat of a
// message with message_end; a beat with only message_end closes the message as it
// stands, so an empty message is allowed. dig_o gives one 160-bit digest per message.
// Bytes are packed into a 32-bit word and written to a 16-word block memory once per
// four bytes. A full block runs 80 rounds, one per cycle, reading the memory for the
// first 16 rounds and extending the schedule in a 16-word shift window after that.
// From the ending beat to the digest beat: a pad write, fill writes up to word 15,
// a compression and the output register load; when the byte count leaves no room
// for the length, a second block adds its own fill writes and one more compression.
// msg_i.ready is high only between compressions. A finished digest waits in the
// output register; if the receiver stalls, the next digest waits before its load.
// Reset is asynchronous and loads the initial chaining words and clears the counts.
`include "sha1_message_digest_top_macros.svh"

module sha1_message_digest_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sha1md_in_if.sink            msg_i,
  sha1md_out_if.source         dig_o
);

  sha1md_pkg::state_e state_q, state_d;

  logic [5:0]  pos_q, pos_d;
  logic [31:0] pack_q, pack_d;
  logic [63:0] cnt_q, cnt_d;
  logic [6:0]  round_q, round_d;
  logic [3:0]  widx_q, widx_d;
  logic        len_blk_q, len_blk_d;
  logic        pad_q, pad_d;
  logic        end_pend_q, end_pend_d;

  logic [31:0] h_q [5];
  logic [31:0] h_d [5];
  logic [31:0] wk_q [5];
  logic [31:0] wk_d [5];
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];

  logic [31:0] blk_mem [sha1md_pkg::BlockWords];
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic        mem_re;
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata_q;

  logic        dig_valid_q;
  logic [63:0] dig_upper_q;
  logic [63:0] dig_middle_q;
  logic [31:0] dig_lower_q;

  logic        in_fire;
  logic        out_free;
  logic        start_comp;
  logic [31:0] byte_word;
  logic [31:0] pad_word;
  logic [31:0] w_cur;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_sum;

  assign msg_i.ready = (state_q == sha1md_pkg::ST_IDLE);
  assign in_fire     = msg_i.valid && msg_i.ready;
  assign out_free    = !dig_valid_q || dig_o.ready;

  // Current byte inserted big-endian at its lane of the packing word.
  always_comb begin
    case (pos_q[1:0])
      2'd0:    byte_word = {msg_i.data_byte, pack_q[23:0]};
      2'd1:    byte_word = {pack_q[31:24], msg_i.data_byte, pack_q[15:0]};
      2'd2:    byte_word = {pack_q[31:16], msg_i.data_byte, pack_q[7:0]};
      default: byte_word = {pack_q[31:8], msg_i.data_byte};
    endcase
  end

  // Word holding the pad marker: earlier bytes kept, later lanes zero.
  always_comb begin
    case (pos_q[1:0])
      2'd0:    pad_word = {sha1md_pkg::PadByte, 24'h0};
      2'd1:    pad_word = {pack_q[31:24], sha1md_pkg::PadByte, 16'h0};
      2'd2:    pad_word = {pack_q[31:16], sha1md_pkg::PadByte, 8'h0};
      default: pad_word = {pack_q[31:8], sha1md_pkg::PadByte};
    endcase
  end

  // Round datapath.
  always_comb begin
    if (round_q < 7'd16) begin
      w_cur = mem_rdata_q;
    end else begin
      w_cur = sha1md_pkg::rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
    end
    if (round_q < 7'd20) begin
      f_val = (wk_q[1] & wk_q[2]) | (~wk_q[1] & wk_q[3]);
      k_val = sha1md_pkg::K0;
    end else if (round_q < 7'd40) begin
      f_val = wk_q[1] ^ wk_q[2] ^ wk_q[3];
      k_val = sha1md_pkg::K1;
    end else if (round_q < 7'd60) begin
      f_val = (wk_q[1] & wk_q[2]) | (wk_q[1] & wk_q[3]) | (wk_q[2] & wk_q[3]);
      k_val = sha1md_pkg::K2;
    end else begin
      f_val = wk_q[1] ^ wk_q[2] ^ wk_q[3];
      k_val = sha1md_pkg::K3;
    end
    t_sum = sha1md_pkg::rotl(wk_q[0], 5) + f_val + wk_q[4] + k_val + w_cur;
  end

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    pack_d     = pack_q;
    cnt_d      = cnt_q;
    round_d    = round_q;
    widx_d     = widx_q;
    len_blk_d  = len_blk_q;
    pad_d      = pad_q;
    end_pend_d = end_pend_q;
    h_d        = h_q;
    wk_d       = wk_q;
    w_d        = w_q;
    mem_we     = 1'b0;
    mem_waddr  = pos_q[5:2];
    mem_wdata  = byte_word;

    case (state_q)
      sha1md_pkg::ST_IDLE: begin
        if (in_fire) begin
          end_pend_d = msg_i.message_end;
          if (msg_i.byte_present) begin
            pack_d = byte_word;
            cnt_d  = cnt_q + 64'd8;
            pos_d  = pos_q + 6'd1;
            mem_we = (pos_q[1:0] == 2'd3);
          end
          if (msg_i.byte_present && (pos_q == 6'd63)) begin
            state_d = sha1md_pkg::ST_ROUND;
          end else if (msg_i.message_end) begin
            state_d = sha1md_pkg::ST_ENDW;
          end
        end
      end
      sha1md_pkg::ST_ENDW: begin
        mem_we     = 1'b1;
        mem_wdata  = pad_word;
        end_pend_d = 1'b0;
        pad_d      = 1'b1;
        // The length fits in this block only if the marker lies before byte 56.
        len_blk_d  = (pos_q[5:3] != 3'd7);
        widx_d     = pos_q[5:2] + 4'd1;
        if (pos_q[5:2] == sha1md_pkg::LenLoIdx) begin
          state_d = sha1md_pkg::ST_ROUND;
        end else begin
          state_d = sha1md_pkg::ST_PAD;
        end
      end
      sha1md_pkg::ST_PAD: begin
        mem_we    = 1'b1;
        mem_waddr = widx_q;
        if (len_blk_q && (widx_q == sha1md_pkg::LenHiIdx)) begin
          mem_wdata = cnt_q[63:32];
        end else if (len_blk_q && (widx_q == sha1md_pkg::LenLoIdx)) begin
          mem_wdata = cnt_q[31:0];
        end else begin
          mem_wdata = '0;
        end
        widx_d = widx_q + 4'd1;
        if (widx_q == sha1md_pkg::LenLoIdx) begin
          state_d = sha1md_pkg::ST_ROUND;
        end
      end
      sha1md_pkg::ST_ROUND: begin
        wk_d[4] = wk_q[3];
        wk_d[3] = wk_q[2];
        wk_d[2] = sha1md_pkg::rotl(wk_q[1], 30);
        wk_d[1] = wk_q[0];
        wk_d[0] = t_sum;
        for (int i = 0; i < 15; i++) begin
          w_d[i] = w_q[i + 1];
        end
        w_d[15] = w_cur;
        if (round_q == 7'(sha1md_pkg::LastRound)) begin
          round_d = '0;
          state_d = sha1md_pkg::ST_FIN;
        end else begin
          round_d = round_q + 7'd1;
        end
      end
      sha1md_pkg::ST_FIN: begin
        for (int i = 0; i < 5; i++) begin
          h_d[i] = h_q[i] + wk_q[i];
        end
        if (pad_q && len_blk_q) begin
          state_d = sha1md_pkg::ST_DONE;
        end else if (pad_q) begin
          // Marker block had no room for the length: a second block follows.
          widx_d    = '0;
          len_blk_d = 1'b1;
          state_d   = sha1md_pkg::ST_PAD;
        end else if (end_pend_q) begin
          state_d = sha1md_pkg::ST_ENDW;
        end else begin
          state_d = sha1md_pkg::ST_IDLE;
        end
      end
      sha1md_pkg::ST_DONE: begin
        if (out_free) begin
          h_d       = sha1md_pkg::InitH;
          cnt_d     = '0;
          pos_d     = '0;
          pad_d     = 1'b0;
          len_blk_d = 1'b0;
          state_d   = sha1md_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sha1md_pkg::ST_IDLE;
      end
    endcase

    if (start_comp) begin
      wk_d = h_q;
    end
  end

  // Word 15 is always the last write before a compression, so the read of word 0
  // issued in that cycle never meets a pending write.
  assign start_comp = (state_d == sha1md_pkg::ST_ROUND) && (state_q != sha1md_pkg::ST_ROUND);
  assign mem_re     = start_comp || ((state_q == sha1md_pkg::ST_ROUND) && (round_q < 7'd15));
  assign mem_raddr  = start_comp ? 4'd0 : (round_q[3:0] + 4'd1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= blk_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha1md_pkg::ST_IDLE;
      pos_q       <= '0;
      cnt_q       <= '0;
      round_q     <= '0;
      widx_q      <= '0;
      len_blk_q   <= 1'b0;
      pad_q       <= 1'b0;
      end_pend_q  <= 1'b0;
      h_q         <= sha1md_pkg::InitH;
      dig_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      round_q    <= round_d;
      widx_q     <= widx_d;
      len_blk_q  <= len_blk_d;
      pad_q      <= pad_d;
      end_pend_q <= end_pend_d;
      h_q        <= h_d;
      if ((state_q == sha1md_pkg::ST_DONE) && out_free) begin
        dig_valid_q <= 1'b1;
      end else if (dig_o.ready) begin
        dig_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pack_q <= pack_d;
    wk_q   <= wk_d;
    w_q    <= w_d;
    if ((state_q == sha1md_pkg::ST_DONE) && out_free) begin
      dig_upper_q  <= {h_q[0], h_q[1]};
      dig_middle_q <= {h_q[2], h_q[3]};
      dig_lower_q  <= h_q[4];
    end
  end

  assign dig_o.valid         = dig_valid_q;
  assign dig_o.digest_upper  = dig_upper_q;
  assign dig_o.digest_middle = dig_middle_q;
  assign dig_o.digest_lower  = dig_lower_q;

  `SHA1MD_ASSERT_SAME(a_round_range, state_q == sha1md_pkg::ST_ROUND, round_q < 7'd80, "round index out of range")
  `SHA1MD_ASSERT_SAME(a_comp_after_last_word, start_comp, mem_we && (mem_waddr == 4'd15), "compression started before word 15 was written")
  `SHA1MD_ASSERT_NEXT(a_digest_loads, (state_q == sha1md_pkg::ST_DONE) && out_free, dig_o.valid && (state_q == sha1md_pkg::ST_IDLE), "digest beat not presented after completion")
  `SHA1MD_ASSERT_NEXT(a_chain_restart, (state_q == sha1md_pkg::ST_DONE) && out_free, (h_q[0] == sha1md_pkg::InitH[0]) && (cnt_q == 64'd0) && (pos_q == 6'd0), "message state not restarted after digest")

endmodule

/* tb/sv/tb_sha1_message_digest_top.sv */
// Self-checking testbench for the streaming SHA-1 digest block, with its own digest predictor.
module tb_sha1_message_digest_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemsTarget = 1800;
  localparam int unsigned DigestsTarget = 20;
  localparam int unsigned HoldCycles = 1000;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned IdlePercent = 28;
  localparam int unsigned NoisePercent = 6;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] middle;
    logic [31:0] lower;
  } digest_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
    logic       known;
    digest_t    digest;
  } dir_row_t;

  localparam digest_t NoDigest = '0;
  localparam digest_t EmptyDigest = '{64'hda39a3ee5e6b4b0d, 64'h3255bfef95601890, 32'hafd80709};
  localparam digest_t DigestA = '{64'h86f7e437faa5a7fc, 64'he15d1ddcb9eaeaea, 32'h377667b8};
  localparam digest_t DigestAbc = '{64'ha9993e364706816a, 64'hba3e25717850c26c, 32'h9cd0d89d};

  // Short messages around the extremes; only the textbook digests are typed in.
  localparam int unsigned DirRowCount = 17;
  localparam dir_row_t DirRows [DirRowCount] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},
    '{8'h61, 1'b1, 1'b1, 1'b1, DigestA},
    '{8'h61, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h62, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h63, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h00, 1'b0, 1'b1, 1'b1, DigestAbc},
    '{8'h5a, 1'b0, 1'b0, 1'b0, NoDigest},
    '{8'hff, 1'b0, 1'b1, 1'b1, EmptyDigest},
    '{8'hff, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h00, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h80, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h7f, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'ha5, 1'b0, 1'b0, 1'b0, NoDigest},
    '{8'h01, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'hfe, 1'b1, 1'b1, 1'b0, NoDigest},
    '{8'h00, 1'b1, 1'b1, 1'b0, NoDigest},
    '{8'hff, 1'b1, 1'b1, 1'b0, NoDigest}
  };

  // Message lengths that put the pad byte and the length field around the first two block boundaries.
  localparam int unsigned SweepCount = 10;
  localparam int unsigned SweepLens [SweepCount] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  logic clk_i;
  logic rst_ni;

  sha1md_in_if  msg_if ();
  sha1md_out_if dig_if ();

  sha1_message_digest_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if.sink),
    .dig_o  (dig_if.source)
  );

  // Predictor state.
  logic [31:0] chain_h [5];
  logic [31:0] blk_w [16];
  int          blk_pos;
  logic [63:0] bit_len;

  digest_t expected_digests [$];

  int unsigned n_errors = 0;
  int unsigned n_items = 0;
  int unsigned n_noise = 0;
  int unsigned n_messages = 0;
  int unsigned n_digests = 0;
  int unsigned n_two_block = 0;
  int unsigned stall_count = 0;
  bit          steady = 1'b0;
  bit          held_off = 1'b0;
  digest_t     seen_want;

  always #5ns clk_i = ~clk_i;

  function automatic void clear_message();
    for (int i = 0; i < 5; i++) begin
      chain_h[i] = sha1md_pkg::InitH[i];
    end
    blk_pos = 0;
    bit_len = '0;
  endfunction

  function automatic void put_byte(input int pos, input logic [7:0] value);
    blk_w[pos / 4][(3 - pos % 4) * 8 +: 8] = value;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    for (int i = 0; i < 16; i++) begin
      w[i] = blk_w[i];
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        tmp = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
        w[t % 16] = {tmp[30:0], tmp[31]};
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = sha1md_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1md_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K3;
      end
      tmp = {a[26:0], a[31:27]} + f + e + k + w[t % 16];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Applies one accepted beat; returns 1 and the digest when the beat ends a message.
  function automatic bit digest_after_beat(input logic [7:0] data_byte, input logic present,
                                           input logic msg_end, output digest_t digest);
    digest = NoDigest;
    if (present) begin
      put_byte(blk_pos, data_byte);
      bit_len += 64'd8;
      blk_pos++;
      if (blk_pos == 64) begin
        compress_block();
        blk_pos = 0;
      end
    end
    if (!msg_end) begin
      return 1'b0;
    end
    put_byte(blk_pos, sha1md_pkg::PadByte);
    blk_pos++;
    // No room left for the length field, so the padding spills into a second block.
    if (blk_pos > 56) begin
      n_two_block++;
      while (blk_pos < 64) begin
        put_byte(blk_pos, 8'h00);
        blk_pos++;
      end
      compress_block();
      blk_pos = 0;
    end
    while (blk_pos < 56) begin
      put_byte(blk_pos, 8'h00);
      blk_pos++;
    end
    blk_w[sha1md_pkg::LenHiIdx] = bit_len[63:32];
    blk_w[sha1md_pkg::LenLoIdx] = bit_len[31:0];
    compress_block();
    digest.upper  = {chain_h[0], chain_h[1]};
    digest.middle = {chain_h[2], chain_h[3]};
    digest.lower  = chain_h[4];
    clear_message();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer_beat(input logic [7:0] data_byte, input logic present,
                            input logic msg_end, input bit known, input digest_t typed);
    digest_t predicted;
    bit      has_digest;
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      msg_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    msg_if.valid        <= 1'b1;
    msg_if.data_byte    <= data_byte;
    msg_if.byte_present <= present;
    msg_if.message_end  <= msg_end;
    do begin
      @(posedge clk_i);
    end while (msg_if.ready !== 1'b1);
    has_digest = digest_after_beat(data_byte, present, msg_end, predicted);
    if (has_digest) begin
      expected_digests.insert(expected_digests.size(), known ? typed : predicted);
    end
    if (present || msg_end) begin
      n_items++;
    end else begin
      n_noise++;
    end
    if (msg_end) begin
      n_messages++;
    end
    @(negedge clk_i);
  endtask

  task automatic send_message(input int unsigned len);
    bit joint_end;
    joint_end = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < NoisePercent) begin
        offer_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NoDigest);
      end
      offer_beat(8'($urandom_range(0, 255)), 1'b1, joint_end && (i == len - 1), 1'b0,
                 NoDigest);
    end
    if (!joint_end) begin
      offer_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NoDigest);
    end
  endtask

  initial begin
    int unsigned len;
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    msg_if.valid        = 1'b0;
    msg_if.data_byte    = '0;
    msg_if.byte_present = 1'b0;
    msg_if.message_end  = 1'b0;
    for (int i = 0; i < 16; i++) begin
      blk_w[i] = '0;
    end
    clear_message();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirRows[i]) begin
      offer_beat(DirRows[i].data_byte, DirRows[i].byte_present, DirRows[i].message_end,
                 DirRows[i].known, DirRows[i].digest);
    end
    foreach (SweepLens[i]) begin
      send_message(SweepLens[i]);
    end

    while (n_items < ItemsTarget || n_messages < DigestsTarget) begin
      steady = (n_items >= 900 && n_items < 1200);
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(52, 68);
        2: len = $urandom_range(110, 130);
        default: len = $urandom_range(0, 200);
      endcase
      send_message(len);
    end
    steady = 1'b0;
    msg_if.valid <= 1'b0;

    while (expected_digests.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_digests.size() != 0) begin
      report_mismatch("digests never delivered", 64'(expected_digests.size()), 64'd0);
    end

    $display("Sent %0d beats (%0d ignored) forming %0d messages, %0d padded into two blocks.",
             n_items, n_noise, n_messages, n_two_block);
    $display("Checked %0d digest beats field by field; %0d mismatches.", n_digests, n_errors);
    if (n_errors == 0) begin
      $display("tb_sha1_message_digest_top: clean");
    end else begin
      $display("tb_sha1_message_digest_top: errors");
    end
    $finish;
  end

  // Digest receiver: random backpressure, one long hold-off, and a stretch always ready.
  initial begin
    dig_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && n_digests >= 6) begin
        held_off = 1'b1;
        dig_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      dig_if.ready <= steady || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && dig_if.valid === 1'b1 && dig_if.ready === 1'b1) begin
      n_digests++;
      if (expected_digests.size() == 0) begin
        report_mismatch("unexpected digest beat", dig_if.digest_upper, 64'd0);
      end else begin
        seen_want = expected_digests.pop_front();
        if (dig_if.digest_upper !== seen_want.upper) begin
          report_mismatch("digest_upper", dig_if.digest_upper, seen_want.upper);
        end
        if (dig_if.digest_middle !== seen_want.middle) begin
          report_mismatch("digest_middle", dig_if.digest_middle, seen_want.middle);
        end
        if (dig_if.digest_lower !== seen_want.lower) begin
          report_mismatch("digest_lower", {32'h0, dig_if.digest_lower},
                          {32'h0, seen_want.lower});
        end
      end
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((msg_if.valid === 1'b1 && msg_if.ready === 1'b1) ||
          (dig_if.valid === 1'b1 && dig_if.ready === 1'b1)) begin
        stall_count <= 0;
      end else if (stall_count >= StallLimit) begin
        $display("Timeout: no beat on either channel for %0d cycles.", StallLimit);
        $display("tb_sha1_message_digest_top: errors");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

endmodule
